[rtl/core/s4rf_pkg.sv]
// ============================================================================
// s4rf_pkg: shared types and constants for the SOCKS4 request filter
// Holds the reply descriptor passed from the front end to the reply
// generator, the protocol codes and the register map.
// ============================================================================
package s4rf_pkg;

    localparam int RULE_W   = 37;
    localparam int CFG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 2;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_CONNECT_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONNECT_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONNECT_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIND_0    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIND_1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIND_2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BIND_PORT = 3'd6;

    // SOCKS4 codes
    localparam logic [7:0] CMD_CONNECT = 8'h01;
    localparam logic [7:0] CMD_BIND    = 8'h02;
    localparam logic [7:0] CODE_GRANT  = 8'h5A;
    localparam logic [7:0] CODE_REJECT = 8'h5B;
    localparam logic [7:0] REPLY_VER   = 8'h00;

    // Number of header bytes that are latched
    localparam logic [3:0] HDR_BYTES = 4'd8;

    typedef struct packed {
        logic        granted;
        logic        domain_form;
        logic [15:0] port;
        logic [31:0] addr;
    } reply_desc_t;

    // A rule hits when it is enabled and every octet is either wildcarded
    // or equal to the address octet.
    function automatic logic rule_hit(input logic [RULE_W-1:0] rule, input logic [31:0] addr);
        logic hit;
        hit = rule[36];
        if (!rule[35] && (addr[31:24] != rule[31:24])) hit = 1'b0;
        if (!rule[34] && (addr[23:16] != rule[23:16])) hit = 1'b0;
        if (!rule[33] && (addr[15:8]  != rule[15:8]))  hit = 1'b0;
        if (!rule[32] && (addr[7:0]   != rule[7:0]))   hit = 1'b0;
        return hit;
    endfunction

endpackage

[rtl/core/s4rf_front.sv]
// ============================================================================
// s4rf_front: request parser and rule check
// Latches the request header, holds the rule registers and turns each
// completed request into one reply descriptor.
// ============================================================================
module s4rf_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic                            s_tlast,
    input  logic                            cfg_valid,
    input  logic [s4rf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [s4rf_pkg::RULE_W-1:0]     cfg_data,
    input  logic                            q_full,
    output logic                            push,
    output s4rf_pkg::reply_desc_t           push_desc
);
    import s4rf_pkg::*;

    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] port_reg, port_next;
    logic [31:0] addr_reg, addr_next;

    logic [RULE_W-1:0] connect_rule_reg [3];
    logic [RULE_W-1:0] bind_rule_reg [3];
    logic [15:0]       bind_port_reg;

    logic accept;
    logic connect_hit, bind_hit, grant, is_bind;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Header update with the byte now on the bus.
    always_comb
    begin
        pos_next  = pos_reg;
        cmd_next  = cmd_reg;
        port_next = port_reg;
        addr_next = addr_reg;
        if (pos_reg < HDR_BYTES)
        begin
            pos_next = pos_reg + 4'd1;
            case (pos_reg[2:0])
                3'd1:    cmd_next = s_tdata;
                3'd2:    port_next[15:8] = s_tdata;
                3'd3:    port_next[7:0] = s_tdata;
                3'd4:    addr_next[31:24] = s_tdata;
                3'd5:    addr_next[23:16] = s_tdata;
                3'd6:    addr_next[15:8] = s_tdata;
                3'd7:    addr_next[7:0] = s_tdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        connect_hit = rule_hit(connect_rule_reg[0], addr_next)
                   || rule_hit(connect_rule_reg[1], addr_next)
                   || rule_hit(connect_rule_reg[2], addr_next);
        bind_hit    = rule_hit(bind_rule_reg[0], addr_next)
                   || rule_hit(bind_rule_reg[1], addr_next)
                   || rule_hit(bind_rule_reg[2], addr_next);
        is_bind     = (cmd_next == CMD_BIND);
        grant       = ((cmd_next == CMD_CONNECT) && connect_hit) || (is_bind && bind_hit);

        push_desc.granted     = grant;
        push_desc.domain_form = (addr_next[31:8] == 24'd0) && (addr_next[7:0] != 8'd0);
        push_desc.port        = (grant && is_bind) ? bind_port_reg : port_next;
        push_desc.addr        = (grant && is_bind) ? 32'd0 : addr_next;
        push                  = accept && s_tlast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            cmd_reg  <= '0;
            port_reg <= '0;
            addr_reg <= '0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                pos_reg  <= '0;
                cmd_reg  <= '0;
                port_reg <= '0;
                addr_reg <= '0;
            end
            else
            begin
                pos_reg  <= pos_next;
                cmd_reg  <= cmd_next;
                port_reg <= port_next;
                addr_reg <= addr_next;
            end
        end
    end

    // Rule registers; an index beyond the map is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            connect_rule_reg[0] <= '0;
            connect_rule_reg[1] <= '0;
            connect_rule_reg[2] <= '0;
            bind_rule_reg[0]    <= '0;
            bind_rule_reg[1]    <= '0;
            bind_rule_reg[2]    <= '0;
            bind_port_reg       <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CONNECT_0: connect_rule_reg[0] <= cfg_data;
                REG_CONNECT_1: connect_rule_reg[1] <= cfg_data;
                REG_CONNECT_2: connect_rule_reg[2] <= cfg_data;
                REG_BIND_0:    bind_rule_reg[0] <= cfg_data;
                REG_BIND_1:    bind_rule_reg[1] <= cfg_data;
                REG_BIND_2:    bind_rule_reg[2] <= cfg_data;
                REG_BIND_PORT: bind_port_reg <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

endmodule

[rtl/core/s4rf_queue.sv]
// ============================================================================
// s4rf_queue: reply descriptor queue
// Two-entry FIFO that lets the parser run ahead of the reply generator.
// ============================================================================
module s4rf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  s4rf_pkg::reply_desc_t push_desc,
    input  logic                  pop,
    output s4rf_pkg::reply_desc_t head_desc,
    output logic                  empty,
    output logic                  full
);
    import s4rf_pkg::*;

    reply_desc_t entry_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;

    assign empty     = (count_reg == 2'd0);
    assign full      = (count_reg == 2'(QUEUE_DEPTH));
    assign head_desc = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: ;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("descriptor queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("descriptor queue underflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QUEUE_DEPTH))
        else $error("descriptor count out of range");

endmodule

[rtl/core/s4rf_back.sv]
// ============================================================================
// s4rf_back: reply generator
// Serializes the head descriptor into eight reply beats through an output
// register.
// ============================================================================
module s4rf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  s4rf_pkg::reply_desc_t head_desc,
    input  logic                  empty,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic [1:0]            m_tuser
);
    import s4rf_pkg::*;

    logic [2:0] idx_reg;
    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic [1:0] user_reg;
    logic       load;
    logic [7:0] byte_sel;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

    assign load = !valid_reg || m_tready;
    assign pop  = load && !empty && (idx_reg == 3'd7);

    always_comb
    begin
        case (idx_reg)
            3'd0:    byte_sel = REPLY_VER;
            3'd1:    byte_sel = head_desc.granted ? CODE_GRANT : CODE_REJECT;
            3'd2:    byte_sel = head_desc.port[15:8];
            3'd3:    byte_sel = head_desc.port[7:0];
            3'd4:    byte_sel = head_desc.addr[31:24];
            3'd5:    byte_sel = head_desc.addr[23:16];
            3'd6:    byte_sel = head_desc.addr[15:8];
            default: byte_sel = head_desc.addr[7:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= !empty;
            if (!empty)
                idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            data_reg <= byte_sel;
            last_reg <= (idx_reg == 3'd7);
            user_reg <= {head_desc.domain_form, head_desc.granted};
        end
    end

endmodule

[rtl/core/socks4_request_filter_top.sv]
// ============================================================================
// socks4_request_filter_top: SOCKS4 request filter and reply generator
// Parses SOCKS4 requests, checks them against connect and bind rules and
// streams back the eight-byte reply.
// ============================================================================
// Request bytes enter on the s_* stream, one beat per byte; s_tlast marks the
// final byte of a request. The first eight bytes are latched as the header
// (command, port, address); later bytes are dropped. Header bytes that never
// arrive read as zero.
// Each request produces eight reply beats on the m_* stream, m_tlast on the
// eighth. m_tuser carries the grant flag and the domain-form flag, the same
// on all eight beats.
// Rules and the bind port are written through the cfg_* channel, which is
// always ready; write only while no request is in flight.
// The input takes one beat per cycle while s_tready is high. The request's
// descriptor is written into the queue at the accepting edge of its last
// byte, and each reply beat then passes through the output register. A reply
// is eight beats long, so the output sets the sustained request rate. A
// two-entry descriptor queue sits between the parser and the reply
// generator; once both entries are waiting, s_tready drops until the
// generator frees one. A stalled m_tready holds the current beat in the
// output register. Reset clears all rules, the header and the queue.
// ============================================================================
module socks4_request_filter_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // Request stream. tdata: request_byte[7:0]. tlast: end_of_request.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    input  logic                           s_tlast,
    // Reply stream. tdata: reply_byte[7:0]. tlast: reply_last.
    // tuser: bit 0 granted, bit 1 domain_form.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,
    output logic                           m_tlast,
    output logic [1:0]                     m_tuser,
    // Configuration writes. cfg_data: rule value, or the port in bits 15:0.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [s4rf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [s4rf_pkg::RULE_W-1:0]    cfg_data
);
    import s4rf_pkg::*;

    reply_desc_t push_desc, head_desc;
    logic        push, pop, q_empty, q_full;

    // Registers are plain flops, so a write is always taken at once.
    assign cfg_ready = 1'b1;

    s4rf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    s4rf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .empty     (q_empty),
        .full      (q_full)
    );

    s4rf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_desc (head_desc),
        .empty     (q_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for socks4_request_filter_top
// Streams SOCKS4 requests into the filter one byte per beat and keeps its own
// copy of the header latch and of the connect and bind rules. Every reply beat
// is compared with the predicted one while both streams stall at random.
// ============================================================================
module tb_top;
    import s4rf_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 8;
    // Cycles allowed after the last expected beat before the rules change or
    // the run ends, so that a stray beat still has room to show up.
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int TIMEOUT_NS    = 2_000_000;

    // Index 7 is outside the register map; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    // Marks a stimulus row whose reply code is left to the predictor.
    localparam logic [7:0] UNTYPED = 8'h00;

    typedef enum {SET_DIRECTED, SET_RANDOM, SET_OPEN, SET_CLOSED} rule_set_t;

    // One reply beat as the filter should send it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       granted;
        logic       domain;
    } reply_beat_t;

    // One row of the directed table. A set reload bit loads the directed rule
    // set, once the filter is idle, before the row's byte goes out.
    typedef struct packed {
        logic       reload;
        logic [7:0] data;
        logic       last;
        logic [7:0] code;
    } probe_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic [1:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [RULE_W-1:0]     cfg_data  = '0;

    // Shadow copy of the filter's registers and header latch.
    logic [RULE_W-1:0]     rule_reg [0:5];
    logic [15:0]           listen_port;
    logic [3:0]            hdr_pos;
    logic [7:0]            hdr_cmd;
    logic [15:0]           hdr_port;
    logic [31:0]           hdr_addr;

    reply_beat_t           reply_beats_due [$];
    int                    bytes_sent   = 0;
    int                    mismatches   = 0;
    int                    src_idle_pct = 0;
    int                    dst_idle_pct = 0;

    // The stimulus toggles hold_kick; the receiver notices the change and then
    // keeps m_tready low while hold_left counts down from HOLD_CYCLES.
    logic                  hold_kick = 1'b0;
    logic                  hold_seen = 1'b0;
    int                    hold_left = 0;

    // Directed requests. Codes are typed in where they are plain from the rule
    // set loaded on row 1: connect rule 1 is 192.*.*.7, bind rule 0 is the
    // literal 0.0.0.5, and nothing admits 0.0.0.0.
    probe_row_t probe_rows [24] = '{
        // A lone byte right after reset: the whole header reads as zero.
        '{1'b0, 8'h04,       1'b1, CODE_REJECT},
        // Connect to 192.0.255.7, port at its maximum, one user id byte.
        '{1'b1, 8'h04,       1'b0, UNTYPED},
        '{1'b0, CMD_CONNECT, 1'b0, UNTYPED},
        '{1'b0, 8'hFF,       1'b0, UNTYPED},
        '{1'b0, 8'hFF,       1'b0, UNTYPED},
        '{1'b0, 8'hC0,       1'b0, UNTYPED},
        '{1'b0, 8'h00,       1'b0, UNTYPED},
        '{1'b0, 8'hFF,       1'b0, UNTYPED},
        '{1'b0, 8'h07,       1'b0, UNTYPED},
        '{1'b0, 8'h00,       1'b1, CODE_GRANT},
        // Bind in domain form, 0.0.0.5, ending on the last header byte.
        '{1'b0, 8'h04,       1'b0, UNTYPED},
        '{1'b0, CMD_BIND,    1'b0, UNTYPED},
        '{1'b0, 8'h00,       1'b0, UNTYPED},
        '{1'b0, 8'h00,       1'b0, UNTYPED},
        '{1'b0, 8'h00,       1'b0, UNTYPED},
        '{1'b0, 8'h00,       1'b0, UNTYPED},
        '{1'b0, 8'h00,       1'b0, UNTYPED},
        '{1'b0, 8'h05,       1'b1, CODE_GRANT},
        // Unknown command, cut short right after the port.
        '{1'b0, 8'h04,       1'b0, UNTYPED},
        '{1'b0, 8'hFF,       1'b0, UNTYPED},
        '{1'b0, 8'h12,       1'b0, UNTYPED},
        '{1'b0, 8'h34,       1'b1, CODE_REJECT},
        // Bind cut short after the command: address 0.0.0.0 hits no rule.
        '{1'b0, 8'h00,       1'b0, UNTYPED},
        '{1'b0, CMD_BIND,    1'b1, CODE_REJECT}
    };

    socks4_request_filter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // True when any of the three rules from base on admits the address. A
    // rule needs its enable bit, and each octet must be wildcarded or equal;
    // wildcard bit 32 + k covers address octet k.
    function automatic logic rule_group_grants(input int base, input logic [31:0] addr);
        logic any_hit;
        logic hit;
        any_hit = 1'b0;
        for (int r = base; r < base + 3; r++) begin
            hit = rule_reg[r][36];
            for (int k = 0; k < 4; k++)
                if (!rule_reg[r][32 + k] && addr[8 * k +: 8] != rule_reg[r][8 * k +: 8])
                    hit = 1'b0;
            any_hit |= hit;
        end
        return any_hit;
    endfunction

    // Follows one accepted request byte. On the closing byte it queues the
    // eight reply beats and clears the header. A typed code, where given,
    // takes the place of the predicted decision.
    task automatic track_request_byte(input logic [7:0] b, input logic last,
                                      input logic [7:0] code);
        logic        grant;
        logic        domain;
        logic [15:0] port;
        logic [31:0] addr;
        logic [63:0] reply_word;
        reply_beat_t beat;
        if (hdr_pos < HDR_BYTES) begin
            case (hdr_pos)
                4'd1: hdr_cmd = b;
                4'd2: hdr_port[15:8] = b;
                4'd3: hdr_port[7:0] = b;
                4'd4, 4'd5, 4'd6, 4'd7: hdr_addr[8 * (7 - hdr_pos) +: 8] = b;
                default: ;
            endcase
            hdr_pos++;
        end
        if (last) begin
            if (hdr_cmd == CMD_CONNECT)
                grant = rule_group_grants(0, hdr_addr);
            else if (hdr_cmd == CMD_BIND)
                grant = rule_group_grants(3, hdr_addr);
            else
                grant = 1'b0;
            if (code != UNTYPED)
                grant = (code == CODE_GRANT);
            // A SOCKS4a request carries 0.0.0.x; it is flagged, not resolved.
            domain = (hdr_addr >= 32'd1) && (hdr_addr <= 32'd255);
            port = hdr_port;
            addr = hdr_addr;
            if (grant && hdr_cmd == CMD_BIND) begin
                port = listen_port;
                addr = '0;
            end
            reply_word = {REPLY_VER, grant ? CODE_GRANT : CODE_REJECT, port, addr};
            for (int k = 0; k < 8; k++) begin
                beat = reply_beat_t'{reply_word[63 - 8 * k -: 8], k == 7, grant, domain};
                reply_beats_due = {reply_beats_due, beat};
            end
            hdr_pos  = '0;
            hdr_cmd  = '0;
            hdr_port = '0;
            hdr_addr = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Writes one register and mirrors it. cfg_valid stays high so that writes
    // can follow back to back; the caller lowers it after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RULE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        if (idx <= REG_BIND_2)
            rule_reg[idx] = val;
        else if (idx == REG_BIND_PORT)
            listen_port = val[15:0];
    endtask

    // Writes all seven registers, plus one write to the unmapped index.
    task automatic load_rule_set(input rule_set_t mode);
        logic [RULE_W-1:0]    val;
        logic [CFG_IDX_W-1:0] idx;
        for (int i = 0; i <= REG_BIND_PORT; i++) begin
            idx = CFG_IDX_W'(i);
            case (mode)
                SET_DIRECTED:
                    case (idx)
                        REG_CONNECT_0: val = {1'b1, 4'b0000, 32'h0A01_0203};
                        REG_CONNECT_1: val = {1'b1, 4'b0110, 32'hC000_0007};
                        // All octets wildcarded but disabled: must never hit.
                        REG_CONNECT_2: val = {1'b0, 4'b1111, 32'h0808_0808};
                        REG_BIND_0:    val = {1'b1, 4'b0000, 32'h0000_0005};
                        REG_BIND_1:    val = {1'b1, 4'b0001, 32'hAC10_0000};
                        REG_BIND_2:    val = {1'b1, 4'b0000, 32'hFFFF_FFFF};
                        default:       val = {21'd0, 16'h1F90};
                    endcase
                SET_OPEN:   val = '1;
                SET_CLOSED: val = '0;
                default:    val = {1'($urandom_range(99) < 85), 4'($urandom), 32'($urandom)};
            endcase
            write_reg(idx, val);
        end
        write_reg(REG_UNMAPPED, {5'($urandom), 32'($urandom)});
        cfg_valid <= 1'b0;
    endtask

    // Offers one request byte, idling first at the current sender rate, and
    // returns at the edge that accepts it with s_tvalid still high.
    task automatic send_request_byte(input logic [7:0] b, input logic last,
                                     input logic [7:0] code);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        bytes_sent++;
        track_request_byte(b, last, code);
    endtask

    // Most requests are well formed, with addresses drawn near the loaded
    // rules so that grants, wildcards and near misses all come up. The rest
    // are random bytes, many of them cut short.
    task automatic send_random_request();
        logic [63:0] hdr_word;
        logic [31:0] addr;
        logic [7:0]  cmd;
        logic [7:0]  b;
        int          rule_sel;
        int          n_hdr;
        int          n_total;
        bit          well_formed;
        well_formed = $urandom_range(99) < 80;
        rule_sel = $urandom_range(5);
        addr = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
                addr = rule_reg[rule_sel][31:0];
                for (int k = 0; k < 4; k++)
                    if (rule_reg[rule_sel][32 + k] || $urandom_range(7) == 0)
                        addr[8 * k +: 8] = 8'($urandom);
            end
            6, 7: addr = 32'($urandom_range(255, 1));
            8: addr = ($urandom_range(1) == 0) ? 32'h0 :
                      ($urandom_range(1) == 0) ? 32'h0000_0100 : 32'hFFFF_FFFF;
            default: ;
        endcase
        case ($urandom_range(9))
            7:       cmd = (rule_sel < 3) ? CMD_BIND : CMD_CONNECT;
            8, 9:    cmd = 8'($urandom);
            default: cmd = (rule_sel < 3) ? CMD_CONNECT : CMD_BIND;
        endcase
        hdr_word = {($urandom_range(9) == 0) ? 8'($urandom) : 8'h04, cmd,
                    16'($urandom), addr};
        if (well_formed) begin
            n_hdr   = 8;
            n_total = 8 + $urandom_range(5);
        end else begin
            hdr_word = {$urandom, $urandom};
            n_hdr    = $urandom_range(8, 1);
            n_total  = n_hdr + (($urandom_range(3) == 0) ? $urandom_range(4) : 0);
        end
        for (int i = 0; i < n_total; i++) begin
            if (i < n_hdr)
                b = hdr_word[63 - 8 * i -: 8];
            else if (well_formed && i == n_total - 1)
                b = 8'h00;
            else
                b = 8'($urandom);
            send_request_byte(b, i == n_total - 1, UNTYPED);
        end
    endtask

    // Stops offering and waits until every predicted beat has arrived.
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (reply_beats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Reply side
    // ------------------------------------------------------------------------

    // Receiver. It stalls at the current rate, except during a hold-off,
    // when it refuses every beat so that the filter backs up into s_tready.
    always @(posedge clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Every accepted reply beat is checked against the oldest prediction.
    always @(posedge clk) begin : reply_check
        reply_beat_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (reply_beats_due.size() == 0) begin
                $display("%0t ns: reply beat with none pending: data=%h last=%b user=%b",
                         $time, m_tdata, m_tlast, m_tuser);
                mismatches++;
            end else begin
                want = reply_beats_due.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last
                        || m_tuser[0] !== want.granted || m_tuser[1] !== want.domain) begin
                    $display("%0t ns: reply mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                             $time, want.data, want.last, want.granted, want.domain,
                             m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int seg_start;
        int seg_bytes;
        foreach (rule_reg[i])
            rule_reg[i] = '0;
        listen_port = '0;
        hdr_pos     = '0;
        hdr_cmd     = '0;
        hdr_port    = '0;
        hdr_addr    = '0;
        // The directed part runs at the first idle setting.
        src_idle_pct = 32;
        dst_idle_pct = 51;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_rows[i]) begin
            if (probe_rows[i].reload) begin
                drain_replies();
                load_rule_set(SET_DIRECTED);
            end
            send_request_byte(probe_rows[i].data, probe_rows[i].last, probe_rows[i].code);
        end

        // Random traffic in four segments. The rules are rewritten between
        // segments, only once the filter has gone quiet. The middle two use
        // the extremes: every rule open, then every rule closed.
        for (int seg = 0; seg < 4; seg++) begin
            drain_replies();
            case (seg)
                0: begin
                    load_rule_set(SET_RANDOM);
                    src_idle_pct = 32;
                    dst_idle_pct = 51;
                end
                1: begin
                    load_rule_set(SET_OPEN);
                    src_idle_pct = 51;
                    dst_idle_pct = 32;
                end
                2: load_rule_set(SET_CLOSED);
                default: begin
                    // No idling at all, and a long receiver hold-off at the
                    // start while requests keep coming at full rate.
                    load_rule_set(SET_RANDOM);
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                    hold_kick <= ~hold_kick;
                end
            endcase
            seg_start = bytes_sent;
            seg_bytes = (seg == 1 || seg == 2) ? 30 : 55;
            while (bytes_sent - seg_start < seg_bytes)
                send_random_request();
        end

        drain_replies();
        if (mismatches == 0)
            $display("socks4_request_filter_top verification clean");
        else
            $display("socks4_request_filter_top verification failed");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(TIMEOUT_NS);
        $display("socks4_request_filter_top verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/s4rf_pkg.sv
rtl/core/s4rf_front.sv
rtl/core/s4rf_queue.sv
rtl/core/s4rf_back.sv
rtl/core/socks4_request_filter_top.sv
sim/tb_top.sv
